/* rtl/core/spk_pkg.sv */
// SPECK-64/96 package: word sizes, round count, key register codes and reset values,
// and the single-round encrypt/decrypt and key-schedule helper functions.
// No dependencies; imported by speck64_96_block_cipher_top.
`default_nettype none

package spk_pkg;

    // Cipher geometry
    localparam int WORD_W   = 32;
    localparam int BLOCK_W  = 2 * WORD_W;
    localparam int ROUNDS   = 26;
    localparam int ALPHA    = 8;
    localparam int BETA     = 3;
    localparam int RK_IDX_W = $clog2(ROUNDS);

    // Configuration port
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 2'd2;

    localparam logic [WORD_W-1:0] KEY_WORD_0_RST = 32'h0302_0100;
    localparam logic [WORD_W-1:0] KEY_WORD_1_RST = 32'h0706_0504;
    localparam logic [WORD_W-1:0] KEY_WORD_2_RST = 32'h0B0A_0908;

    // Mode codes
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // One item in flight through the round pipeline
    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
    } stage_t;

    function automatic logic [WORD_W-1:0] ror_a(input logic [WORD_W-1:0] v);
        return (v >> ALPHA) | (v << (WORD_W - ALPHA));
    endfunction

    function automatic logic [WORD_W-1:0] rol_a(input logic [WORD_W-1:0] v);
        return (v << ALPHA) | (v >> (WORD_W - ALPHA));
    endfunction

    function automatic logic [WORD_W-1:0] ror_b(input logic [WORD_W-1:0] v);
        return (v >> BETA) | (v << (WORD_W - BETA));
    endfunction

    function automatic logic [WORD_W-1:0] rol_b(input logic [WORD_W-1:0] v);
        return (v << BETA) | (v >> (WORD_W - BETA));
    endfunction

    // One round in either direction, selected by the item's mode
    function automatic stage_t speck_round(input stage_t s, input logic [WORD_W-1:0] rk_enc,
                                           input logic [WORD_W-1:0] rk_dec);
        stage_t            r;
        logic [WORD_W-1:0] ex;
        logic [WORD_W-1:0] dy;
        ex     = (ror_a(s.x) + s.y) ^ rk_enc;
        dy     = ror_b(s.x ^ s.y);
        r.mode = s.mode;
        if (s.mode == MODE_DECRYPT)
        begin
            r.y = dy;
            r.x = rol_a((s.x ^ rk_dec) - dy);
        end
        else
        begin
            r.x = ex;
            r.y = rol_b(s.y) ^ ex;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/speck64_96_block_cipher_top.sv */
// SPECK-64/96 encrypt/decrypt core: 26-stage unrolled round pipeline plus a
// sequential key expander filling a round-key register file. Depends on spk_pkg.
// An accepted transaction enters the first round stage and passes every stage to m_axis_tvalid;
// one caught in the skid stage by an output stall enters the pipe once it moves again.
// Throughput: one block per cycle when no output stall or key expansion holds the input;
// mode may change on every transaction. Reset (rst_n, async, low): key words return to
// their defaults and the key expander runs, one round key per cycle; the same expansion
// follows every key write, and s_axis_tready stays low throughout.
`default_nettype none

module speck64_96_block_cipher_top
    import spk_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // Configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data,

    // Input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [BLOCK_W-1:0]   s_axis_tdata,   // [63:0] block_in (x upper, y lower)
    input  wire logic                 s_axis_tuser,   // [0] mode (0 encrypt, 1 decrypt)

    // Output stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [BLOCK_W-1:0]        m_axis_tdata    // [63:0] block_out (x upper, y lower)
);

    // ------------------------------------------------------------------
    // Key registers and key expansion
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]   key0_reg;
    logic [WORD_W-1:0]   key1_reg;
    logic [WORD_W-1:0]   key2_reg;
    logic                exp_busy_reg;
    logic [RK_IDX_W-1:0] exp_cnt_reg;
    logic [WORD_W-1:0]   exp_k_reg;
    logic [WORD_W-1:0]   exp_l0_reg;
    logic [WORD_W-1:0]   exp_l1_reg;
    logic [WORD_W-1:0]   rk_reg [ROUNDS];

    logic [WORD_W-1:0]   exp_lsel;
    logic [WORD_W-1:0]   exp_l_next;
    logic [WORD_W-1:0]   exp_k_next;
    logic [RK_IDX_W-1:0] exp_step;

    // Key word writes; any write restarts the expansion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg     <= KEY_WORD_0_RST;
            key1_reg     <= KEY_WORD_1_RST;
            key2_reg     <= KEY_WORD_2_RST;
            exp_busy_reg <= 1'b1;
            exp_cnt_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_WORD_0: key0_reg <= cfg_data;
                REG_KEY_WORD_1: key1_reg <= cfg_data;
                REG_KEY_WORD_2: key2_reg <= cfg_data;
                default: ;
            endcase
            exp_busy_reg <= 1'b1;
            exp_cnt_reg  <= '0;
        end
        else if (exp_busy_reg)
        begin
            if (exp_cnt_reg == RK_IDX_W'(ROUNDS - 1))
                exp_busy_reg <= 1'b0;
            exp_cnt_reg <= exp_cnt_reg + 1'b1;
        end
    end

    // Schedule step i = count - 1; odd i works on the second l word
    always_comb
    begin
        exp_step   = exp_cnt_reg - 1'b1;
        exp_lsel   = exp_step[0] ? exp_l1_reg : exp_l0_reg;
        exp_l_next = (exp_k_reg + ror_a(exp_lsel)) ^ WORD_W'(exp_step);
        exp_k_next = rol_b(exp_k_reg) ^ exp_l_next;
    end

    // Schedule datapath and round-key file, one key per cycle
    always_ff @(posedge clk)
    begin
        if (exp_busy_reg && !cfg_we)
        begin
            if (exp_cnt_reg == '0)
            begin
                exp_k_reg  <= key0_reg;
                exp_l0_reg <= key1_reg;
                exp_l1_reg <= key2_reg;
                rk_reg[0]  <= key0_reg;
            end
            else
            begin
                exp_k_reg <= exp_k_next;
                if (exp_step[0])
                    exp_l1_reg <= exp_l_next;
                else
                    exp_l0_reg <= exp_l_next;
                rk_reg[exp_cnt_reg] <= exp_k_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input skid stage
    // ------------------------------------------------------------------
    logic   adv;
    logic   in_fire;
    logic   skid_vld_reg;
    stage_t skid_reg;
    stage_t in_item;
    stage_t entry;
    logic   entry_vld;

    logic [ROUNDS-1:0] vld_reg;
    stage_t            st_reg  [ROUNDS];
    stage_t            st_next [ROUNDS];

    assign adv           = !vld_reg[ROUNDS-1] || m_axis_tready;
    assign s_axis_tready = !skid_vld_reg && !exp_busy_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_item.mode = s_axis_tuser;
        in_item.x    = s_axis_tdata[BLOCK_W-1:WORD_W];
        in_item.y    = s_axis_tdata[WORD_W-1:0];
        entry        = skid_vld_reg ? skid_reg : in_item;
        entry_vld    = skid_vld_reg || in_fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_vld_reg <= 1'b0;
        else if (adv)
            skid_vld_reg <= 1'b0;
        else if (in_fire)
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!adv && in_fire)
            skid_reg <= in_item;
    end

    // ------------------------------------------------------------------
    // Round pipeline: stage j applies encrypt round j or decrypt round 25-j
    // ------------------------------------------------------------------
    for (genvar j = 0; j < ROUNDS; j++)
    begin : g_round
        if (j == 0)
        begin : g_first
            assign st_next[j] = speck_round(entry, rk_reg[j], rk_reg[ROUNDS-1-j]);
        end
        else
        begin : g_rest
            assign st_next[j] = speck_round(st_reg[j-1], rk_reg[j], rk_reg[ROUNDS-1-j]);
        end
    end

    // Valid bits travel with the data; whole pipe holds on a downstream stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[ROUNDS-2:0], entry_vld};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < ROUNDS; j++)
                st_reg[j] <= st_next[j];
        end
    end

    // Output
    assign m_axis_tvalid = vld_reg[ROUNDS-1];
    assign m_axis_tdata  = {st_reg[ROUNDS-1].x, st_reg[ROUNDS-1].y};

endmodule

`default_nettype wire

/* tb/sv/speck64_96_block_cipher_top_tb.sv */
// Self-checking testbench for speck64_96_block_cipher_top: SPECK-64/96 encrypt and decrypt
// transactions predicted per item and checked against the output stream in order.
// Depends on spk_pkg and speck64_96_block_cipher_top.
`default_nettype none

module speck64_96_block_cipher_top_tb;
    import spk_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    // Index beyond the last key register; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [BLOCK_W-1:0]   s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [BLOCK_W-1:0]   m_axis_tdata;

    // Predictor state: key words and the round keys derived from them
    logic [WORD_W-1:0]    key_words [3];
    logic [WORD_W-1:0]    round_keys [ROUNDS];

    // Blocks still to come out of the cipher, oldest first
    logic [BLOCK_W-1:0]   pending_blocks [$];
    logic [BLOCK_W-1:0]   recent_ciphertexts [$];

    int                   fail_count;
    int                   cycle_count;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   hold_left;
    bit                   hold_request;

    speck64_96_block_cipher_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("speck64_96_block_cipher_top test failed");
                $finish;
            end
        end
    end

    // Word rotations
    function automatic logic [WORD_W-1:0] rot_r(input logic [WORD_W-1:0] v, input int n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] rot_l(input logic [WORD_W-1:0] v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // Key schedule: k0 is the first round key, l words alternate
    function automatic void expand_round_keys();
        logic [WORD_W-1:0] k;
        logic [WORD_W-1:0] l [2];
        logic [WORD_W-1:0] nl;
        k             = key_words[REG_KEY_WORD_0];
        l[0]          = key_words[REG_KEY_WORD_1];
        l[1]          = key_words[REG_KEY_WORD_2];
        round_keys[0] = k;
        for (int i = 0; i < ROUNDS - 1; i++)
        begin
            nl              = (k + rot_r(l[i % 2], ALPHA)) ^ WORD_W'(i);
            l[i % 2]        = nl;
            k               = rot_l(k, BETA) ^ nl;
            round_keys[i+1] = k;
        end
    endfunction

    // Expected output block for one input transaction
    function automatic logic [BLOCK_W-1:0] speck_predict(input logic mode,
                                                          input logic [BLOCK_W-1:0] blk);
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        x = blk[BLOCK_W-1:WORD_W];
        y = blk[WORD_W-1:0];
        if (mode == MODE_ENCRYPT)
        begin
            for (int r = 0; r < ROUNDS; r++)
            begin
                x = (rot_r(x, ALPHA) + y) ^ round_keys[r];
                y = rot_l(y, BETA) ^ x;
            end
        end
        else
        begin
            for (int r = ROUNDS - 1; r >= 0; r--)
            begin
                y = rot_r(x ^ y, BETA);
                x = rot_l((x ^ round_keys[r]) - y, ALPHA);
            end
        end
        return {x, y};
    endfunction

    // Receiver: random back-pressure, plus a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else
                m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Output checker: each transaction against the oldest expected block
    always @(posedge clk)
    begin
        logic [BLOCK_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_blocks.size() == 0)
            begin
                $error("block_out: unexpected transaction, actual %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_blocks.pop_front();
                if (m_axis_tdata !== want)
                begin
                    $error("block_out mismatch: expected %h, actual %h", want, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    // Offer one block; returns at the edge where it is accepted
    task automatic send_block(input logic mode, input logic [BLOCK_W-1:0] blk);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = blk;
        s_axis_tuser  = mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_blocks.push_back(speck_predict(mode, blk));
        if (mode == MODE_ENCRYPT)
        begin
            recent_ciphertexts.push_back(pending_blocks[$]);
            if (recent_ciphertexts.size() > 16)
                void'(recent_ciphertexts.pop_front());
        end
    endtask

    // Stop offering and wait until every expected block has come out
    task automatic drain_blocks();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_blocks.size() != 0)
            @(posedge clk);
    endtask

    // Key register write; only called while the cipher is idle
    task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        if (idx <= REG_KEY_WORD_2)
        begin
            key_words[idx] = value;
            expand_round_keys();
        end
    endtask

    task automatic load_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] l0,
                            input logic [WORD_W-1:0] l1);
        write_key(REG_KEY_WORD_0, k0);
        write_key(REG_KEY_WORD_1, l0);
        write_key(REG_KEY_WORD_2, l1);
    endtask

    // Default key after reset: extremes of the block in both directions and an encrypt/decrypt round trip
    task automatic test_reset_key();
        send_block(MODE_ENCRYPT, 64'h0);
        send_block(MODE_ENCRYPT, {BLOCK_W{1'b1}});
        send_block(MODE_DECRYPT, 64'h0);
        send_block(MODE_DECRYPT, {BLOCK_W{1'b1}});
        send_block(MODE_ENCRYPT, 64'h8000_0000_0000_0001);
        send_block(MODE_DECRYPT, 64'h0000_0001_8000_0000);
        send_block(MODE_ENCRYPT, 64'h0123_4567_89AB_CDEF);
        send_block(MODE_DECRYPT, recent_ciphertexts[$]);
        drain_blocks();
    endtask

    // Published test vector, checked against the predictor and the block
    task automatic test_known_answer();
        load_key(32'h0302_0100, 32'h0B0A_0908, 32'h1312_1110);
        if (speck_predict(MODE_ENCRYPT, 64'h7461_4620_736E_6165) !== 64'h9F79_52EC_4175_946C)
        begin
            $error("block_out mismatch: expected %h, actual %h", 64'h9F79_52EC_4175_946C,
                   speck_predict(MODE_ENCRYPT, 64'h7461_4620_736E_6165));
            fail_count++;
        end
        send_block(MODE_ENCRYPT, 64'h7461_4620_736E_6165);
        send_block(MODE_DECRYPT, 64'h9F79_52EC_4175_946C);
        drain_blocks();
    endtask

    // Key extremes, an ignored write, and a key change seen by the very next block
    task automatic test_key_extremes();
        load_key(32'h0, 32'h0, 32'h0);
        send_block(MODE_ENCRYPT, 64'h0);
        send_block(MODE_DECRYPT, {BLOCK_W{1'b1}});
        drain_blocks();
        load_key({WORD_W{1'b1}}, {WORD_W{1'b1}}, {WORD_W{1'b1}});
        send_block(MODE_ENCRYPT, {BLOCK_W{1'b1}});
        send_block(MODE_DECRYPT, 64'h0);
        drain_blocks();
        write_key(REG_UNUSED, $urandom);
        send_block(MODE_ENCRYPT, 64'hDEAD_BEEF_0BAD_F00D);
        drain_blocks();
        write_key(REG_KEY_WORD_1, 32'h5555_AAAA);
        send_block(MODE_ENCRYPT, 64'hDEAD_BEEF_0BAD_F00D);
        drain_blocks();
    endtask

    // Random blocks under a fresh random key, with round trips and extremes mixed in
    task automatic test_random_traffic(input int count, input int s_idle, input int r_idle);
        int                 sent;
        int                 pick;
        logic               mode;
        logic [BLOCK_W-1:0] blk;
        sent          = 0;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        load_key($urandom, $urandom, $urandom);
        while (sent < count)
        begin
            pick = $urandom_range(99);
            mode = $urandom_range(1) ? MODE_DECRYPT : MODE_ENCRYPT;
            blk  = {$urandom, $urandom};
            if (pick < 25)
            begin
                // encrypt then decrypt the same block back
                send_block(MODE_ENCRYPT, blk);
                send_block(MODE_DECRYPT, recent_ciphertexts[$]);
                sent += 2;
            end
            else if (pick < 35 && recent_ciphertexts.size() != 0)
            begin
                send_block(MODE_DECRYPT,
                           recent_ciphertexts[$urandom_range(recent_ciphertexts.size() - 1)]);
                sent++;
            end
            else if (pick < 45)
            begin
                send_block(mode, $urandom_range(1) ? {BLOCK_W{1'b1}} : {BLOCK_W{1'b0}});
                sent++;
            end
            else
            begin
                send_block(mode, blk);
                sent++;
            end
        end
        drain_blocks();
    endtask

    // Long receiver hold-off while blocks keep coming, so the pipeline backs up
    task automatic test_backpressure(input int count);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        for (int i = 0; i < count; i++)
            send_block($urandom_range(1) ? MODE_DECRYPT : MODE_ENCRYPT, {$urandom, $urandom});
        drain_blocks();
    endtask

    // Sequence
    initial
    begin
        fail_count    = 0;
        hold_request  = 1'b0;
        send_idle_pct = 17;
        recv_idle_pct = 47;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_KEY_WORD_0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_ENCRYPT;
        key_words[REG_KEY_WORD_0] = KEY_WORD_0_RST;
        key_words[REG_KEY_WORD_1] = KEY_WORD_1_RST;
        key_words[REG_KEY_WORD_2] = KEY_WORD_2_RST;
        expand_round_keys();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_key();
        test_known_answer();
        test_key_extremes();
        test_random_traffic(120, 17, 47);
        test_random_traffic(120, 47, 17);
        test_random_traffic(120, 0, 0);
        test_backpressure(80);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_blocks.size() != 0)
        begin
            $error("block_out: %0d expected transactions never arrived", pending_blocks.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("speck64_96_block_cipher_top test passed");
        else
            $display("speck64_96_block_cipher_top test failed");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/spk_pkg.sv
rtl/core/speck64_96_block_cipher_top.sv
tb/sv/speck64_96_block_cipher_top_tb.sv
